[rtl/core/rgbft_pkg.sv]
`default_nettype none

package rgbft_pkg;

  // tint colors in rgb555 layout
  localparam logic [15:0] TINT_RED    = 16'h7C00;
  localparam logic [15:0] TINT_YELLOW = 16'h7FE0;
  localparam logic [15:0] TINT_PURPLE = 16'h7C1F;
  localparam logic [15:0] TINT_BLUE   = 16'h001F;
  localparam logic [15:0] TINT_NONE   = 16'h0000;

  // clears the low bit of the red and green channels so a sum never carries across
  localparam logic [15:0] AVG_MASK = 16'hFBDF;

  localparam int unsigned TABLE_DEPTH = 23;

  typedef enum logic [2:0] {
    LVL_NONE = 3'd0,
    LVL_1    = 3'd1,
    LVL_2    = 3'd2,
    LVL_3    = 3'd3,
    LVL_4    = 3'd4,
    LVL_5    = 3'd5,
    LVL_6    = 3'd6,
    LVL_7    = 3'd7
  } tint_level_t;

  typedef struct packed {
    tint_level_t level;
    logic [15:0] tint;
  } tint_sel_t;

  // flash index to level and tint color
  localparam tint_sel_t TINT_TABLE [TABLE_DEPTH] = '{
    '{LVL_NONE, TINT_NONE},
    '{LVL_1, TINT_RED},    '{LVL_1, TINT_RED},    '{LVL_2, TINT_RED},
    '{LVL_3, TINT_RED},    '{LVL_4, TINT_RED},    '{LVL_5, TINT_RED},
    '{LVL_6, TINT_RED},    '{LVL_7, TINT_RED},
    '{LVL_1, TINT_YELLOW}, '{LVL_1, TINT_YELLOW}, '{LVL_2, TINT_YELLOW},
    '{LVL_2, TINT_YELLOW},
    '{LVL_1, TINT_PURPLE}, '{LVL_1, TINT_PURPLE}, '{LVL_2, TINT_PURPLE},
    '{LVL_3, TINT_PURPLE}, '{LVL_4, TINT_PURPLE}, '{LVL_5, TINT_PURPLE},
    '{LVL_6, TINT_PURPLE}, '{LVL_7, TINT_PURPLE},
    '{LVL_2, TINT_BLUE},
    '{LVL_2, TINT_YELLOW}
  };

  // per-channel average of two rgb555 words
  function automatic logic [15:0] avg16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] sum;
    sum = {1'b0, a & AVG_MASK} + {1'b0, b & AVG_MASK};
    return sum[16:1];
  endfunction

  // five-bit channel to eight bits by top-bit replication
  function automatic logic [7:0] widen5(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

endpackage

`default_nettype wire

[rtl/core/rgbft_blend.sv]
`default_nettype none

module rgbft_blend
  import rgbft_pkg::*;
(
  input  wire logic [7:0]  flash_index,
  input  wire logic [15:0] pixel,
  output logic      [15:0] tinted,
  output logic      [7:0]  red,
  output logic      [7:0]  green,
  output logic      [7:0]  blue
);

  tint_sel_t   sel;
  logic [15:0] t;
  logic [15:0] x1;
  logic [15:0] x2_pt;
  logic [15:0] x2_tt;
  logic [15:0] x3_p2;
  logic [15:0] x3_pt;
  logic [15:0] x3_tt;

  // index lookup, out-of-range indices mean no tint
  always_comb begin
    if (flash_index < 8'(TABLE_DEPTH)) begin
      sel = TINT_TABLE[flash_index[4:0]];
    end else begin
      sel = TINT_TABLE[0];
    end
  end

  assign t = sel.tint;

  // shared first step, then the second and third steps of each chain
  assign x1    = avg16(pixel, t);
  assign x2_pt = avg16(pixel, x1);
  assign x2_tt = avg16(x1, t);
  assign x3_p2 = avg16(pixel, x2_pt);
  assign x3_pt = avg16(pixel, x2_tt);
  assign x3_tt = avg16(x2_tt, t);

  // pick the chain for the level
  always_comb begin
    unique case (sel.level)
      LVL_1:   tinted = x3_p2;
      LVL_2:   tinted = x2_pt;
      LVL_3:   tinted = x3_pt;
      LVL_4:   tinted = x1;
      LVL_5:   tinted = x2_tt;
      LVL_6:   tinted = x3_tt;
      LVL_7:   tinted = t;
      default: tinted = pixel;
    endcase
  end

  // channel expansion
  assign red   = widen5(tinted[14:10]);
  assign green = widen5(tinted[9:5]);
  assign blue  = widen5(tinted[4:0]);

endmodule

`default_nettype wire

[rtl/core/rgb555_flash_tint_and_expand_unit.sv]
// rgb555 flash tint and rgb888 expansion
//
// input channel: in_valid/in_ready carry one rgb555 pixel per beat on
// in_pixel_in. output channel: out_valid/out_ready carry the blended
// pixel and its three 8-bit channels per beat.
// cfg_we/cfg_wdata write the flash index; write it only
// while no pixel is in flight.
//
// a beat passes the input register, then the tint chain and expansion
// into the output register. throughput is one pixel per cycle while
// the receiver keeps out_ready high; the tint chain is a single
// combinational pass of up to three averaging adders.
//
// reset clears both pipeline valids and the flash index (no tint).
// when the receiver stalls, the output register holds its beat, the
// input register fills behind it, and in_ready drops once both are full.
`default_nettype none

module rgb555_flash_tint_and_expand_unit
  import rgbft_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_pixel_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [15:0] out_tinted_pixel,
  output logic      [7:0]  out_red_out,
  output logic      [7:0]  out_green_out,
  output logic      [7:0]  out_blue_out
);

  logic [7:0]  flash_index_r;
  logic        s1_valid_r;
  logic [15:0] s1_pixel_r;
  logic        out_valid_r;
  logic [15:0] tinted_r;
  logic [7:0]  red_r;
  logic [7:0]  green_r;
  logic [7:0]  blue_r;
  logic        s2_ready;
  logic        s1_load;
  logic        s2_load;
  logic [15:0] tinted_nxt;
  logic [7:0]  red_nxt;
  logic [7:0]  green_nxt;
  logic [7:0]  blue_nxt;

  // handshake control
  assign s2_ready = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_ready;
  assign s1_load  = in_valid && in_ready;
  assign s2_load  = s1_valid_r && s2_ready;

  // flash index register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flash_index_r <= '0;
    end else if (cfg_we) begin
      flash_index_r <= cfg_wdata;
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_pixel_r <= in_pixel_in;
    end
  end

  rgbft_blend u_blend (
    .flash_index (flash_index_r),
    .pixel       (s1_pixel_r),
    .tinted      (tinted_nxt),
    .red         (red_nxt),
    .green       (green_nxt),
    .blue        (blue_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (s2_load) begin
      tinted_r <= tinted_nxt;
      red_r    <= red_nxt;
      green_r  <= green_nxt;
      blue_r   <= blue_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tinted_pixel = tinted_r;
  assign out_red_out      = red_r;
  assign out_green_out    = green_r;
  assign out_blue_out     = blue_r;

endmodule

`default_nettype wire

[test/rgb555_flash_tint_and_expand_unit_test.sv]
`timescale 1ns / 100ps

module rgb555_flash_tint_and_expand_unit_test
  import rgbft_pkg::*;
();

  // one output beat: blended word plus its widened channels
  typedef struct packed {
    logic [15:0] tinted;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } rgb_beat_t;

  // corner pixels (all-zero, all-one, pure channels, bit 15 alone) and bit patterns
  localparam logic [15:0] EDGE_PIXELS [12] = '{
    16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7C00, 16'h03E0,
    16'h001F, 16'h5555, 16'hAAAA, 16'h0421, 16'hFBDF, 16'h0001
  };

  class pixel_scoreboard;
    rgb_beat_t   pending_beats[$];
    logic [7:0]  flash_index;
    int unsigned mismatches;
    int unsigned checked;

    function new();
      flash_index = 8'd0;
      mismatches  = 0;
      checked     = 0;
    endfunction

    // channel-wise mean; the mask drops the red and green low bits so no carry crosses
    function logic [15:0] mean_word(logic [15:0] a, logic [15:0] b);
      logic [16:0] total;
      total = 17'(a & AVG_MASK) + 17'(b & AVG_MASK);
      return 16'(total >> 1);
    endfunction

    function logic [7:0] widen_channel(logic [4:0] c);
      return (8'(c) << 3) | (8'(c) >> 2);
    endfunction

    // blended pixel and channels for the current flash index
    function rgb_beat_t tinted_beat(logic [15:0] pix);
      tint_level_t lvl;
      logic [15:0] tint;
      logic [15:0] x;
      rgb_beat_t   beat;
      lvl  = LVL_NONE;
      tint = TINT_NONE;
      if (flash_index >= 8'd1 && flash_index <= 8'd8) begin
        tint = TINT_RED;
        lvl  = (flash_index <= 8'd2) ? LVL_1 : tint_level_t'(3'(flash_index - 8'd1));
      end else if (flash_index >= 8'd13 && flash_index <= 8'd20) begin
        tint = TINT_PURPLE;
        lvl  = (flash_index <= 8'd14) ? LVL_1 : tint_level_t'(3'(flash_index - 8'd13));
      end else if (flash_index >= 8'd9 && flash_index <= 8'd12) begin
        tint = TINT_YELLOW;
        lvl  = (flash_index <= 8'd10) ? LVL_1 : LVL_2;
      end else if (flash_index == 8'd21) begin
        tint = TINT_BLUE;
        lvl  = LVL_2;
      end else if (flash_index == 8'd22) begin
        tint = TINT_YELLOW;
        lvl  = LVL_2;
      end
      // averaging chain per level
      case (lvl)
        LVL_1: begin
          x = mean_word(pix, tint);
          x = mean_word(pix, x);
          x = mean_word(pix, x);
        end
        LVL_2: begin
          x = mean_word(pix, tint);
          x = mean_word(pix, x);
        end
        LVL_3: begin
          x = mean_word(pix, tint);
          x = mean_word(x, tint);
          x = mean_word(pix, x);
        end
        LVL_4: x = mean_word(pix, tint);
        LVL_5: begin
          x = mean_word(pix, tint);
          x = mean_word(x, tint);
        end
        LVL_6: begin
          x = mean_word(pix, tint);
          x = mean_word(x, tint);
          x = mean_word(x, tint);
        end
        LVL_7: x = tint;
        default: x = pix;
      endcase
      beat.tinted = x;
      beat.red    = widen_channel(x[14:10]);
      beat.green  = widen_channel(x[9:5]);
      beat.blue   = widen_channel(x[4:0]);
      return beat;
    endfunction

    function void note_pixel(logic [15:0] pix);
      pending_beats.push_back(tinted_beat(pix));
    endfunction

    function int unsigned pending();
      return pending_beats.size();
    endfunction

    task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      mismatches++;
      if (mismatches <= 50)
        $display("mismatch at %0t ns: %s got %h want %h", $time, what, got, want);
    endtask

    task check_beat(rgb_beat_t got);
      rgb_beat_t want;
      if (pending_beats.size() == 0) begin
        report_mismatch("beat with nothing pending", got.tinted, 16'h0000);
        return;
      end
      want = pending_beats.pop_front();
      checked++;
      if (got.tinted !== want.tinted)
        report_mismatch("tinted_pixel", got.tinted, want.tinted);
      if (got.red !== want.red)
        report_mismatch("red_out", 16'(got.red), 16'(want.red));
      if (got.green !== want.green)
        report_mismatch("green_out", 16'(got.green), 16'(want.green));
      if (got.blue !== want.blue)
        report_mismatch("blue_out", 16'(got.blue), 16'(want.blue));
    endtask
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_pixel_in = 16'h0000;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_tinted_pixel;
  logic [7:0]  out_red_out;
  logic [7:0]  out_green_out;
  logic [7:0]  out_blue_out;

  pixel_scoreboard sb = new();

  bit          idling = 1'b1;
  int unsigned long_hold = 0;
  int unsigned hold_left = 0;
  int unsigned pixels_sent = 0;
  int unsigned settings_used = 0;

  rgb555_flash_tint_and_expand_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel_in      (in_pixel_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tinted_pixel (out_tinted_pixel),
    .out_red_out      (out_red_out),
    .out_green_out    (out_green_out),
    .out_blue_out     (out_blue_out)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: check accepted beats, then pick ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready)
      sb.check_beat('{out_tinted_pixel, out_red_out, out_green_out, out_blue_out});
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (long_hold > 0) begin
      hold_left = long_hold - 1;
      long_hold = 0;
      out_ready <= 1'b0;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // offer one beat, with an optional idle burst ahead of it
  task automatic send_pixel(input logic [15:0] pix);
    int unsigned gap;
    gap = 0;
    if (idling && $urandom_range(0, 5) == 0)
      gap = $urandom_range(1, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_pixel_in <= pix;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_pixel(pix);
    pixels_sent++;
  endtask

  // mostly random words, now and then a corner value
  function automatic logic [15:0] mixed_pixel();
    if ($urandom_range(0, 7) == 0)
      return EDGE_PIXELS[$urandom_range(0, 11)];
    return 16'($urandom());
  endfunction

  // stop offering and let every pending beat come out
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_index(input logic [7:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.flash_index = value;
    settings_used++;
  endtask

  task automatic run_phase(input logic [7:0] value, input int unsigned count);
    program_index(value);
    idling = ($urandom_range(0, 3) != 0);
    repeat (count) send_pixel(mixed_pixel());
  endtask

  // unknown indices worth visiting on top of the table range
  localparam logic [7:0] OUTSIDE_INDICES [6] = '{8'd23, 8'd24, 8'd127, 8'd128, 8'd254, 8'd255};

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: corner pixels with no tint after reset, then full replace and a two-step chain
    foreach (EDGE_PIXELS[i]) send_pixel(EDGE_PIXELS[i]);
    program_index(8'd20);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'h8000);
    program_index(8'd6);
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);
    send_pixel(16'h8421);

    // every table entry, with one long receiver stall while the sender keeps offering
    for (int idx = 0; idx <= 22; idx++) begin
      if (idx == 10) begin
        program_index(8'(idx));
        long_hold = 60;
        repeat (20) send_pixel(mixed_pixel());
      end else begin
        run_phase(8'(idx), 20);
      end
    end
    foreach (OUTSIDE_INDICES[i]) run_phase(OUTSIDE_INDICES[i], 20);

    // random settings, then a closing stretch at full rate
    run_phase(8'($urandom_range(0, 255)), 30);
    run_phase(8'($urandom_range(1, 22)), 30);
    run_phase(8'($urandom_range(0, 255)), 30);
    program_index(8'($urandom_range(1, 22)));
    idling = 1'b0;
    repeat (80) send_pixel(mixed_pixel());

    drain();
    $display("covered %0d pixels over %0d flash index settings (all table entries and unknowns)",
             pixels_sent, settings_used);
    $display("%0d beats compared, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #(5_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
